// File: hdl/pmst_pkg.sv
// Shared types, constants and the weight memory address map for the MST engine.
// No dependencies; imported by prim_mst_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

package pmst_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = 4;
    localparam int VCNT_W       = 5;
    localparam int WEIGHT_BITS  = 10;
    localparam int TOTAL_W      = 14;
    localparam int ADDR_W       = 2 * VIDX_W;

    localparam int IN_FIELDS_W  = 2 * VIDX_W + WEIGHT_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * VIDX_W + WEIGHT_BITS + 1 + TOTAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [VIDX_W-1:0]      t_vidx;
    typedef logic [VCNT_W-1:0]      t_vcnt;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [TOTAL_W-1:0]     t_total;
    typedef logic [ADDR_W-1:0]      t_addr;

    localparam t_weight W_MAX     = '1;
    localparam t_total  TOTAL_MAX = '1;
    localparam t_vcnt   VCNT_MIN  = VCNT_W'(2);
    localparam t_vcnt   VCNT_MAXV = VCNT_W'(MAX_VERTICES);
    localparam t_vcnt   VCNT_RST  = VCNT_W'(16);

    // opcodes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // register index decoded from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // kind of read in flight in the memory pipeline
    localparam logic [1:0] MODE_SEED  = 2'd0;
    localparam logic [1:0] MODE_INIT  = 2'd1;
    localparam logic [1:0] MODE_ROUND = 2'd2;

    // matrix is symmetric: keep one triangle, lower index in the high bits
    function automatic t_addr tri_addr(input t_vidx a, input t_vidx b);
        t_addr addr;
        if (a < b) begin
            addr = {a, b};
        end else begin
            addr = {b, a};
        end
        return addr;
    endfunction

endpackage

`default_nettype wire

// File: hdl/prim_mst_engine_unit.sv
// Prim minimum spanning tree engine over a stored 16-vertex weight matrix.
// Load beat (tuser 0): writes one edge. Run beat (tuser 1): with n vertices, a seed
// scan over all pairs emits the first tree edge, a setup pass follows, and each later
// round emits one more tree edge; the single read port of the weight memory paces
// every scan.
// Reset: synchronous; a clear pass over all 256 entries fills the matrix with the maximum
// weight, during which no beat is accepted (configuration writes still are).
// Depends on pmst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prim_mst_engine_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // row_vertex[3:0], col_vertex[7:4], edge_weight[17:8], zero pad
    input  wire logic [pmst_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // opcode[0]
    input  wire logic [0:0]                         i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tree_from[3:0], tree_to[7:4], tree_weight[17:8], no_edge[18],
    // total_cost[32:19], zero pad
    output logic [pmst_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    import pmst_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SEED  = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    logic [2:0]        r_state, n_state;
    t_addr             r_clr;
    t_vcnt             r_vcount;
    t_vcnt             r_n;
    logic [MAX_VERTICES-1:0] r_in_tree;

    t_weight           mem [2**ADDR_W];
    t_weight           r_rd_data;
    logic              r_rd_valid;
    logic [1:0]        r_rd_mode;
    t_vidx             r_rd_i, r_rd_j;

    t_vidx             r_si, r_sj;
    t_vidx             r_k, r_p;
    t_vidx             r_sel, r_selto;
    t_weight           r_best;
    logic              r_found;
    logic              r_first;
    t_vidx             r_left;
    t_total            r_total;
    t_weight           r_dist [MAX_VERTICES];
    t_vidx             r_near [MAX_VERTICES];

    logic              r_ovalid;
    t_vidx             r_o_from, r_o_to;
    t_weight           r_o_w;
    logic              r_o_noedge;
    t_total            r_o_total;
    logic              r_o_last;

    logic              in_op;
    t_vidx             in_row, in_col;
    t_weight           in_w, load_w;
    logic              in_fire, run_fire, load_we;
    logic              mem_we;
    t_addr             mem_waddr, mem_raddr;
    t_weight           mem_wdata;
    logic              issue;
    logic [1:0]        issue_mode;
    t_vcnt             n_clamp;
    t_vidx             n_last, n_last2;
    logic              cfg_idx, cfg_we;
    t_weight           cur_d, nd;
    t_vidx             cur_n, nn;
    logic              upd, take;
    logic              emit_fire;
    t_total            total_base;
    logic [TOTAL_W:0]  total_sum;
    t_total            total_sat;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_we  = psel && penable && pwrite && pready && (cfg_idx == REG_VERTEX_COUNT);
    assign prdata  = (cfg_idx == REG_VERTEX_COUNT) ? 32'(r_vcount) : '0;

    // input decode
    assign in_op   = i_s_axis_tuser[0];
    assign in_row  = i_s_axis_tdata[VIDX_W-1:0];
    assign in_col  = i_s_axis_tdata[2*VIDX_W-1:VIDX_W];
    assign in_w    = i_s_axis_tdata[IN_FIELDS_W-1:2*VIDX_W];
    assign load_w  = (in_w == '0) ? W_MAX : in_w;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign run_fire = in_fire && (in_op == OP_RUN);
    assign load_we  = in_fire && (in_op == OP_LOAD) && (in_row != in_col);

    assign n_clamp = (r_vcount < VCNT_MIN) ? VCNT_MIN :
                     (r_vcount > VCNT_MAXV) ? VCNT_MAXV : r_vcount;
    assign n_last  = VIDX_W'(r_n - VCNT_W'(1));
    assign n_last2 = VIDX_W'(r_n - VCNT_W'(2));

    // weight memory write: clear pass or edge load
    assign mem_we    = (r_state == S_CLEAR) || load_we;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : tri_addr(in_row, in_col);
    assign mem_wdata = (r_state == S_CLEAR) ? W_MAX : load_w;

    always_comb begin
        issue      = 1'b0;
        issue_mode = MODE_SEED;
        mem_raddr  = {r_si, r_sj};
        case (r_state)
            S_SEED: begin
                issue = 1'b1;
            end
            S_INIT: begin
                issue      = 1'b1;
                issue_mode = MODE_INIT;
                mem_raddr  = tri_addr(r_sj, r_k);
            end
            S_ROUND: begin
                issue      = 1'b1;
                issue_mode = MODE_ROUND;
                mem_raddr  = tri_addr(r_sj, r_p);
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // round compare: relax against the newly added vertex, then pick the lightest
    assign cur_d = r_dist[r_rd_j];
    assign cur_n = r_near[r_rd_j];
    assign upd   = cur_d > r_rd_data;
    assign nd    = upd ? r_rd_data : cur_d;
    assign nn    = upd ? r_p : cur_n;
    assign take  = !r_found || (nd < r_best);

    assign emit_fire  = (r_state == S_EMIT) && (!r_ovalid || i_m_axis_tready);
    assign total_base = r_first ? '0 : r_total;
    assign total_sum  = {1'b0, total_base} + (TOTAL_W + 1)'(r_best);
    assign total_sat  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (run_fire) n_state = S_SEED;
            end
            S_SEED: begin
                if ((r_si == n_last2) && (r_sj == n_last)) n_state = S_DRAIN;
            end
            S_INIT, S_ROUND: begin
                if (r_sj == n_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = (r_rd_mode == MODE_INIT) ? S_ROUND : S_EMIT;
            end
            S_EMIT: begin
                if (emit_fire) begin
                    if (r_left == VIDX_W'(1)) begin
                        n_state = S_IDLE;
                    end else if (r_first) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_ROUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_vcount   <= VCNT_RST;
            r_rd_valid <= 1'b0;
            r_ovalid   <= 1'b0;
            r_in_tree  <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= issue;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (cfg_we) r_vcount <= pwdata[VCNT_W-1:0];
            if (emit_fire) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (run_fire) begin
                r_in_tree <= '0;
            end else if (emit_fire) begin
                r_in_tree[r_sel] <= 1'b1;
                if (r_first) r_in_tree[r_selto] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_mode <= issue_mode;
        r_rd_i    <= r_si;
        r_rd_j    <= r_sj;

        if (run_fire) begin
            r_n     <= n_clamp;
            r_si    <= '0;
            r_sj    <= VIDX_W'(1);
            r_best  <= W_MAX;
            r_sel   <= '0;
            r_selto <= VIDX_W'(1);
            r_first <= 1'b1;
            r_left  <= VIDX_W'(n_clamp - VCNT_W'(1));
        end

        // advance the scan address
        if (r_state == S_SEED) begin
            if (r_sj == n_last) begin
                r_si <= r_si + 1'b1;
                r_sj <= r_si + VIDX_W'(2);
            end else begin
                r_sj <= r_sj + 1'b1;
            end
        end else if ((r_state == S_INIT) || (r_state == S_ROUND)) begin
            // wrap to vertex 0 so the next pass starts from the top
            if (r_sj == n_last) begin
                r_sj <= '0;
            end else begin
                r_sj <= r_sj + 1'b1;
            end
        end

        if (r_rd_valid) begin
            case (r_rd_mode)
                MODE_SEED: begin
                    if (r_rd_data < r_best) begin
                        r_best  <= r_rd_data;
                        r_sel   <= r_rd_i;
                        r_selto <= r_rd_j;
                    end
                end
                MODE_INIT: begin
                    r_dist[r_rd_j] <= r_rd_data;
                    r_near[r_rd_j] <= r_k;
                end
                MODE_ROUND: begin
                    if (!r_in_tree[r_rd_j]) begin
                        r_dist[r_rd_j] <= nd;
                        r_near[r_rd_j] <= nn;
                        if (take) begin
                            r_best  <= nd;
                            r_sel   <= r_rd_j;
                            r_selto <= nn;
                            r_found <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_found <= r_found;
                end
            endcase
        end

        if (emit_fire) begin
            r_o_from   <= r_sel;
            r_o_to     <= r_selto;
            r_o_w      <= r_best;
            r_o_noedge <= (r_best == W_MAX);
            r_o_total  <= total_sat;
            r_o_last   <= (r_left == VIDX_W'(1));
            r_total    <= total_sat;
            r_left     <= r_left - 1'b1;
            r_first    <= 1'b0;
            r_sj       <= '0;
            r_found    <= 1'b0;
            // first beat adds both seed vertices
            if (r_first) begin
                r_k <= r_sel;
                r_p <= r_selto;
            end else begin
                r_p <= r_sel;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_total, r_o_noedge, r_o_w,
                              r_o_to, r_o_from};

endmodule

`default_nettype wire
